// ===== rtl/spa_pkg.sv =====
// Shared types and constants for the sparse polynomial adder.
// Used by the controller, the datapath and the top level; no dependencies.
package spa_pkg;

	// Field widths of the input and result words.
	localparam int KIND_W = 2;
	localparam int COEF_W = 32;
	localparam int EXP_W  = 16;
	localparam int SUM_W  = 33;

	// Item kinds on the input channel. Code 3 is unused and ignored.
	typedef enum logic [KIND_W-1:0] {
		KIND_APPEND_A = 2'd0,
		KIND_APPEND_B = 2'd1,
		KIND_RUN      = 2'd2
	} kind_t;

	// Controller states, one-hot.
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_FETCH  = 4'b0010,
		ST_CMP    = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	// Source of the merged term captured in one compare step.
	typedef enum logic [1:0] {
		SEL_A   = 2'd0,
		SEL_B   = 2'd1,
		SEL_SUM = 2'd2
	} cand_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      wr_a;
		logic      wr_b;
		logic      set_ovf;
		logic      adv_a;
		logic      adv_b;
		logic      take;
		cand_sel_t sel;
		logic      finish;
	} spa_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic a_full;
		logic b_full;
		logic have_a;
		logic have_b;
		logic exp_eq;
		logic a_gt;
		logic sum_nz;
		logic pend_valid;
		logic out_free;
	} spa_stat_t;

endpackage

// ===== rtl/spa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module spa_ram #(
	parameter int Width = 8,
	parameter int Depth = 16,
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem_q [Depth];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/spa_ctrl.sv =====
// Controller state machine of the sparse polynomial adder.
// Depends on spa_pkg for the state, kind, command and status types.
module spa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  spa_pkg::spa_stat_t stat,
	output spa_pkg::spa_cmd_t  cmd
);

	spa_pkg::state_t state_q, state_d;

	// Input words are taken only between runs.
	assign in_ready = (state_q == spa_pkg::ST_IDLE);

	// Next state and command decode.
	always_comb begin
		logic produce;
		logic step_a;
		logic step_b;
		state_d  = state_q;
		cmd      = '0;
		cmd.sel  = spa_pkg::SEL_A;
		produce  = 1'b0;
		step_a   = 1'b0;
		step_b   = 1'b0;
		case (state_q)
			spa_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (kind)
						spa_pkg::KIND_APPEND_A: begin
							cmd.wr_a    = !stat.a_full;
							cmd.set_ovf = stat.a_full;
						end
						spa_pkg::KIND_APPEND_B: begin
							cmd.wr_b    = !stat.b_full;
							cmd.set_ovf = stat.b_full;
						end
						spa_pkg::KIND_RUN: begin
							state_d = spa_pkg::ST_FETCH;
						end
						default: begin
						end
					endcase
				end
			end
			spa_pkg::ST_FETCH: begin
				// Read addresses are the list heads; data shows up next cycle.
				state_d = spa_pkg::ST_CMP;
			end
			spa_pkg::ST_CMP: begin
				if (!stat.have_a && !stat.have_b) begin
					state_d = spa_pkg::ST_FINISH;
				end else begin
					// Pick the term to pass on and which heads move.
					if (stat.have_a && stat.have_b) begin
						if (stat.exp_eq) begin
							cmd.sel = spa_pkg::SEL_SUM;
							produce = stat.sum_nz;
							step_a  = 1'b1;
							step_b  = 1'b1;
						end else if (stat.a_gt) begin
							cmd.sel = spa_pkg::SEL_A;
							produce = 1'b1;
							step_a  = 1'b1;
						end else begin
							cmd.sel = spa_pkg::SEL_B;
							produce = 1'b1;
							step_b  = 1'b1;
						end
					end else if (stat.have_a) begin
						cmd.sel = spa_pkg::SEL_A;
						produce = 1'b1;
						step_a  = 1'b1;
					end else begin
						cmd.sel = spa_pkg::SEL_B;
						produce = 1'b1;
						step_b  = 1'b1;
					end
					// Hold the step while the pending term cannot move out.
					if (!(produce && stat.pend_valid && !stat.out_free)) begin
						cmd.take  = produce;
						cmd.adv_a = step_a;
						cmd.adv_b = step_b;
						state_d   = spa_pkg::ST_FETCH;
					end
				end
			end
			spa_pkg::ST_FINISH: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = spa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = spa_pkg::ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/spa_dp.sv =====
// Datapath of the sparse polynomial adder: term stores, counts, merge
// compare, pending term and output register. Depends on spa_pkg and spa_ram.
module spa_dp #(
	parameter int TERMS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic signed [spa_pkg::COEF_W-1:0] coef,
	input  logic [spa_pkg::EXP_W-1:0]      expon,
	input  spa_pkg::spa_cmd_t              cmd,
	output spa_pkg::spa_stat_t             stat,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [spa_pkg::SUM_W-1:0] sum_coef,
	output logic [spa_pkg::EXP_W-1:0]      sum_expon,
	output logic                           zero_poly,
	output logic                           last,
	output logic                           dropped
);

	localparam int CntW  = $clog2(TERMS + 1);
	localparam int AddrW = (TERMS > 1) ? $clog2(TERMS) : 1;
	localparam int TermW = spa_pkg::COEF_W + spa_pkg::EXP_W;

	logic [CntW-1:0] a_cnt_q, b_cnt_q;
	logic [CntW-1:0] ia_q, jb_q;
	logic            ovf_q;

	logic [TermW-1:0] a_rd, b_rd;
	logic [TermW-1:0] wr_term;

	logic signed [spa_pkg::COEF_W-1:0] a_coef, b_coef;
	logic [spa_pkg::EXP_W-1:0]         a_exp, b_exp;
	logic signed [spa_pkg::SUM_W-1:0]  a_wide, b_wide, sum;
	logic signed [spa_pkg::SUM_W-1:0]  cand_coef;
	logic [spa_pkg::EXP_W-1:0]         cand_exp;

	logic                              pend_valid_q;
	logic signed [spa_pkg::SUM_W-1:0]  pend_coef_q;
	logic [spa_pkg::EXP_W-1:0]         pend_exp_q;

	logic out_valid_q;
	logic out_load;

	assign wr_term = {coef, expon};

	// List A and list B term stores, written at the fill count.
	spa_ram #(.Width(TermW), .Depth(TERMS)) u_ram_a (
		.clk   (clk),
		.we    (cmd.wr_a),
		.waddr (a_cnt_q[AddrW-1:0]),
		.wdata (wr_term),
		.raddr (ia_q[AddrW-1:0]),
		.rdata (a_rd)
	);

	spa_ram #(.Width(TermW), .Depth(TERMS)) u_ram_b (
		.clk   (clk),
		.we    (cmd.wr_b),
		.waddr (b_cnt_q[AddrW-1:0]),
		.wdata (wr_term),
		.raddr (jb_q[AddrW-1:0]),
		.rdata (b_rd)
	);

	// Head terms and their widened sum.
	assign a_coef = a_rd[TermW-1:spa_pkg::EXP_W];
	assign a_exp  = a_rd[spa_pkg::EXP_W-1:0];
	assign b_coef = b_rd[TermW-1:spa_pkg::EXP_W];
	assign b_exp  = b_rd[spa_pkg::EXP_W-1:0];
	assign a_wide = {a_coef[spa_pkg::COEF_W-1], a_coef};
	assign b_wide = {b_coef[spa_pkg::COEF_W-1], b_coef};
	assign sum    = a_wide + b_wide;

	// Candidate term chosen by the controller.
	always_comb begin
		case (cmd.sel)
			spa_pkg::SEL_A: begin
				cand_coef = a_wide;
				cand_exp  = a_exp;
			end
			spa_pkg::SEL_B: begin
				cand_coef = b_wide;
				cand_exp  = b_exp;
			end
			spa_pkg::SEL_SUM: begin
				cand_coef = sum;
				cand_exp  = a_exp;
			end
			default: begin
				cand_coef = a_wide;
				cand_exp  = a_exp;
			end
		endcase
	end

	// Status for the controller.
	always_comb begin
		stat.a_full     = (a_cnt_q == CntW'(TERMS));
		stat.b_full     = (b_cnt_q == CntW'(TERMS));
		stat.have_a     = (ia_q < a_cnt_q);
		stat.have_b     = (jb_q < b_cnt_q);
		stat.exp_eq     = (a_exp == b_exp);
		stat.a_gt       = (a_exp > b_exp);
		stat.sum_nz     = (sum != '0);
		stat.pend_valid = pend_valid_q;
		stat.out_free   = !out_valid_q || out_ready;
	end

	// The output register loads when a newer term pushes the pending one out,
	// or at the end of a run.
	assign out_load = (cmd.take && pend_valid_q) || cmd.finish;

	// Counts, list heads, drop flag and valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_cnt_q      <= '0;
			b_cnt_q      <= '0;
			ia_q         <= '0;
			jb_q         <= '0;
			ovf_q        <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.wr_a) begin
				a_cnt_q <= a_cnt_q + CntW'(1);
			end
			if (cmd.wr_b) begin
				b_cnt_q <= b_cnt_q + CntW'(1);
			end
			if (cmd.set_ovf) begin
				ovf_q <= 1'b1;
			end
			if (cmd.adv_a) begin
				ia_q <= ia_q + CntW'(1);
			end
			if (cmd.adv_b) begin
				jb_q <= jb_q + CntW'(1);
			end
			if (cmd.take) begin
				pend_valid_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.finish) begin
				a_cnt_q      <= '0;
				b_cnt_q      <= '0;
				ia_q         <= '0;
				jb_q         <= '0;
				ovf_q        <= 1'b0;
				pend_valid_q <= 1'b0;
			end
		end
	end

	// Pending term and output word payload.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			pend_coef_q <= cand_coef;
			pend_exp_q  <= cand_exp;
		end
		if (out_load) begin
			dropped <= ovf_q;
			last    <= cmd.finish;
			if (pend_valid_q) begin
				sum_coef  <= pend_coef_q;
				sum_expon <= pend_exp_q;
				zero_poly <= 1'b0;
			end else begin
				sum_coef  <= '0;
				sum_expon <= '0;
				zero_poly <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/sparse_polynomial_adder.sv =====
// Top level of the sparse polynomial adder: controller plus datapath.
// Depends on spa_pkg, spa_ctrl, spa_dp and spa_ram.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid, in_ready  | kind, coef, expon
//  out     | out_valid, out_ready| sum_coef, sum_expon, zero_poly, last, dropped
//
// Append words are accepted back to back.
// A run word repeats a merge step (registered store read, then compare),
// then closes with a last read, the compare that finds both lists spent,
// and the finish.
// Reset empties both lists and clears the drop flag; store contents are
// not cleared. A stalled output holds the merge at its next step; the input
// stays blocked until the run's final word sits in the output register.
module sparse_polynomial_adder #(
	parameter int TERMS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [spa_pkg::KIND_W-1:0]        kind,
	input  logic signed [spa_pkg::COEF_W-1:0] coef,
	input  logic [spa_pkg::EXP_W-1:0]         expon,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [spa_pkg::SUM_W-1:0]  sum_coef,
	output logic [spa_pkg::EXP_W-1:0]         sum_expon,
	output logic                              zero_poly,
	output logic                              last,
	output logic                              dropped
);

	spa_pkg::spa_cmd_t  cmd;
	spa_pkg::spa_stat_t stat;

	// Sequencing of appends and the merge.
	spa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Term stores, merge compare and output register.
	spa_dp #(.TERMS(TERMS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef      (coef),
		.expon     (expon),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sum_coef  (sum_coef),
		.sum_expon (sum_expon),
		.zero_poly (zero_poly),
		.last      (last),
		.dropped   (dropped)
	);

endmodule

// ===== dv/sparse_polynomial_adder_tb.sv =====
// Self-checking testbench for the sparse polynomial adder.
// Depends on spa_pkg and sparse_polynomial_adder; loads term lists, runs merges
// and checks every sum word against a behavioral merge kept in this file.
`timescale 1ns / 100ps

module sparse_polynomial_adder_tb;

	localparam int TERMS = 16;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 2 * (2 * TERMS) + 16;
	localparam int RANDOM_WORDS = 300;
	localparam logic [spa_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

	// One expected sum word.
	typedef struct {
		logic signed [spa_pkg::SUM_W-1:0] coef;
		logic [spa_pkg::EXP_W-1:0]        expon;
		logic                             zero;
		logic                             last;
		logic                             dropped;
	} sum_term_t;

	logic                              clk;
	logic                              arst_n;
	logic                              in_valid;
	logic                              in_ready;
	logic [spa_pkg::KIND_W-1:0]        kind;
	logic signed [spa_pkg::COEF_W-1:0] coef;
	logic [spa_pkg::EXP_W-1:0]         expon;
	logic                              out_valid;
	logic                              out_ready;
	logic signed [spa_pkg::SUM_W-1:0]  sum_coef;
	logic [spa_pkg::EXP_W-1:0]         sum_expon;
	logic                              zero_poly;
	logic                              last;
	logic                              dropped;

	// Shadow copy of the two term lists and the drop flag.
	logic signed [spa_pkg::COEF_W-1:0] list_a_coefs[TERMS];
	logic [spa_pkg::EXP_W-1:0]         list_a_expons[TERMS];
	int                                list_a_len;
	logic signed [spa_pkg::COEF_W-1:0] list_b_coefs[TERMS];
	logic [spa_pkg::EXP_W-1:0]         list_b_expons[TERMS];
	int                                list_b_len;
	logic                              term_dropped;

	sum_term_t pending_sums[$];
	int        error_count;
	int        words_sent;
	int        idle_cycles;
	logic      steady_flow;

	sparse_polynomial_adder #(.TERMS(TERMS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.coef      (coef),
		.expon     (expon),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sum_coef  (sum_coef),
		.sum_expon (sum_expon),
		.zero_poly (zero_poly),
		.last      (last),
		.dropped   (dropped)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Idle length: mostly none, some short, a few long.
	function automatic int pick_gap();
		int r;
		if (steady_flow)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Coefficients lean toward the extremes, zero and small values.
	function automatic logic signed [spa_pkg::COEF_W-1:0] rand_coef();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return '0;
			1: return 32'sh7FFF_FFFF;
			2: return 32'sh8000_0000;
			3, 4: return $signed($urandom_range(0, 20)) - 10;
			default: return $urandom;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $realtime);
		error_count++;
	endtask

	task automatic push_sum(input logic signed [spa_pkg::SUM_W-1:0] c,
			input logic [spa_pkg::EXP_W-1:0] e, inout sum_term_t run_q[$]);
		sum_term_t t;
		t.coef = c;
		t.expon = e;
		t.zero = 1'b0;
		t.last = 1'b0;
		t.dropped = term_dropped;
		run_q.push_back(t);
	endtask

	// Apply one accepted word to the shadow lists; a run queues its sum words.
	task automatic merge_polys(input logic [spa_pkg::KIND_W-1:0] k,
			input logic signed [spa_pkg::COEF_W-1:0] c, input logic [spa_pkg::EXP_W-1:0] e);
		sum_term_t                        run_q[$];
		logic signed [spa_pkg::SUM_W-1:0] s;
		int                               i;
		int                               j;
		i = 0;
		j = 0;
		if (k == spa_pkg::KIND_APPEND_A) begin
			if (list_a_len >= TERMS) begin
				term_dropped = 1'b1;
			end else begin
				list_a_coefs[list_a_len] = c;
				list_a_expons[list_a_len] = e;
				list_a_len++;
			end
		end else if (k == spa_pkg::KIND_APPEND_B) begin
			if (list_b_len >= TERMS) begin
				term_dropped = 1'b1;
			end else begin
				list_b_coefs[list_b_len] = c;
				list_b_expons[list_b_len] = e;
				list_b_len++;
			end
		end else if (k == spa_pkg::KIND_RUN) begin
			while (i < list_a_len && j < list_b_len) begin
				if (list_a_expons[i] == list_b_expons[j]) begin
					s = list_a_coefs[i];
					s = s + list_b_coefs[j];
					if (s != 0)
						push_sum(s, list_a_expons[i], run_q);
					i++;
					j++;
				end else if (list_a_expons[i] > list_b_expons[j]) begin
					push_sum(list_a_coefs[i], list_a_expons[i], run_q);
					i++;
				end else begin
					push_sum(list_b_coefs[j], list_b_expons[j], run_q);
					j++;
				end
			end
			for (; i < list_a_len; i++)
				push_sum(list_a_coefs[i], list_a_expons[i], run_q);
			for (; j < list_b_len; j++)
				push_sum(list_b_coefs[j], list_b_expons[j], run_q);
			// An empty sum still produces one word flagged as the zero polynomial.
			if (run_q.size() == 0) begin
				push_sum('0, '0, run_q);
				run_q[0].zero = 1'b1;
			end
			run_q[run_q.size() - 1].last = 1'b1;
			foreach (run_q[n])
				pending_sums.push_back(run_q[n]);
			list_a_len = 0;
			list_b_len = 0;
			term_dropped = 1'b0;
		end
	endtask

	// Present one word after a random gap and hold it until it is taken.
	task automatic send_word(input logic [spa_pkg::KIND_W-1:0] k,
			input logic signed [spa_pkg::COEF_W-1:0] c, input logic [spa_pkg::EXP_W-1:0] e);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		kind = k;
		coef = c;
		expon = e;
		do
			@(posedge clk);
		while (!in_ready);
		merge_polys(k, c, e);
		if (k != KIND_UNUSED)
			words_sent++;
	endtask

	// The unused kind must leave the lists alone; an empty run gives the zero polynomial.
	task automatic test_ignored_and_empty();
		send_word(KIND_UNUSED, 32'sh1234_5678, 16'hFFFF);
		send_word(spa_pkg::KIND_RUN, '0, '0);
	endtask

	// Extreme coefficients and exponents, a cancelling pair and an unpaired zero term.
	task automatic test_extreme_terms();
		send_word(spa_pkg::KIND_APPEND_A, 32'sh7FFF_FFFF, 16'hFFFF);
		send_word(spa_pkg::KIND_APPEND_B, 32'sh7FFF_FFFF, 16'hFFFF);
		send_word(spa_pkg::KIND_APPEND_A, 32'sh8000_0000, 16'd100);
		send_word(spa_pkg::KIND_APPEND_B, 32'sh8000_0000, 16'd100);
		send_word(spa_pkg::KIND_APPEND_A, 32'sd5, 16'd7);
		send_word(spa_pkg::KIND_APPEND_B, -32'sd5, 16'd7);
		send_word(spa_pkg::KIND_APPEND_A, '0, 16'd3);
		send_word(spa_pkg::KIND_APPEND_B, 32'sd9, 16'd0);
		send_word(spa_pkg::KIND_RUN, '1, '1);
	endtask

	// Every term cancels, so the run reports the zero polynomial.
	task automatic test_full_cancel();
		send_word(spa_pkg::KIND_APPEND_A, 32'sd7, 16'd10);
		send_word(spa_pkg::KIND_APPEND_B, -32'sd7, 16'd10);
		send_word(spa_pkg::KIND_RUN, '0, '0);
	endtask

	// Mostly sorted list pairs with shared exponents, some overfilled lists, some noise.
	task automatic test_random_merges();
		logic [spa_pkg::EXP_W-1:0]         pool[TERMS+3];
		logic signed [spa_pkg::COEF_W-1:0] ca;
		int                                mode;
		int                                npool;
		int                                cur;
		int                                rem;
		int                                dec;
		int                                pick;
		while (words_sent < RANDOM_WORDS) begin
			steady_flow = ($urandom_range(0, 4) == 0);
			mode = $urandom_range(0, 9);
			if (mode == 0) begin
				// Unsorted words of any kind, unused kind included.
				repeat ($urandom_range(1, 6))
					send_word(spa_pkg::KIND_W'($urandom_range(0, 3)), $urandom,
						spa_pkg::EXP_W'($urandom));
			end else begin
				// Build a strictly descending exponent pool, then share it between the lists.
				npool = (mode == 1) ? TERMS + 3 : $urandom_range(1, TERMS + 2);
				cur = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(npool - 1, 65535);
				for (int k = 0; k < npool; k++) begin
					pool[k] = spa_pkg::EXP_W'(cur);
					rem = npool - 1 - k;
					if (rem > 0) begin
						dec = (cur - rem + 1) / rem;
						if (dec > (1 << $urandom_range(1, 15)))
							dec = 1 << $urandom_range(1, 15);
						if (dec < 1)
							dec = 1;
						cur -= $urandom_range(1, dec);
					end
				end
				for (int k = 0; k < npool; k++) begin
					pick = (mode == 1) ? 2 * $urandom_range(0, 1) : $urandom_range(0, 3);
					ca = rand_coef();
					if (pick == 0 || pick == 2)
						send_word(spa_pkg::KIND_APPEND_A, ca, pool[k]);
					if (pick == 1)
						send_word(spa_pkg::KIND_APPEND_B, rand_coef(), pool[k]);
					if (pick == 2)
						send_word(spa_pkg::KIND_APPEND_B,
							($urandom_range(0, 2) == 0) ? -ca : rand_coef(), pool[k]);
				end
			end
			send_word(spa_pkg::KIND_RUN, $urandom, spa_pkg::EXP_W'($urandom));
		end
		steady_flow = 1'b0;
	endtask

	// Main sequence: reset, directed tests, random merges, drain and verdict.
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = spa_pkg::KIND_APPEND_A;
		coef = '0;
		expon = '0;
		steady_flow = 1'b0;
		error_count = 0;
		words_sent = 0;
		list_a_len = 0;
		list_b_len = 0;
		term_dropped = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_ignored_and_empty();
		test_extreme_terms();
		test_full_cancel();
		test_random_merges();

		@(negedge clk);
		in_valid = 1'b0;
		while (pending_sums.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Output back-pressure, changed at the falling edge.
	initial begin : out_ready_driver
		int stall_left;
		int gap;
		stall_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else begin
				gap = pick_gap();
				out_ready = (gap == 0);
				stall_left = (gap > 0) ? gap - 1 : 0;
			end
		end
	end

	// Compare each accepted sum word with the oldest expected one.
	always @(posedge clk) begin
		sum_term_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_sums.size() == 0) begin
				report_mismatch("unexpected word, sum_expon", sum_expon, -1);
			end else begin
				want = pending_sums.pop_front();
				if (sum_coef !== want.coef)
					report_mismatch("sum_coef", sum_coef, want.coef);
				if (sum_expon !== want.expon)
					report_mismatch("sum_expon", sum_expon, want.expon);
				if (zero_poly !== want.zero)
					report_mismatch("zero_poly", zero_poly, want.zero);
				if (last !== want.last)
					report_mismatch("last", last, want.last);
				if (dropped !== want.dropped)
					report_mismatch("dropped", dropped, want.dropped);
			end
		end
	end

	// Watchdog: ends the run when no word moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Watchdog: no word moved for %0d cycles", IDLE_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

endmodule

// ===== sim.f =====
rtl/spa_pkg.sv
rtl/spa_ram.sv
rtl/spa_ctrl.sv
rtl/spa_dp.sv
rtl/sparse_polynomial_adder.sv
dv/sparse_polynomial_adder_tb.sv
